[hdl/dbhsl_pkg.sv]
// ---------------------------------------------------------------------------
// dbhsl_pkg
// Shared widths, constants and types of the dB HSL to RGB pixel unit.
// ---------------------------------------------------------------------------
package dbhsl_pkg;

  // fixed-point shape
  localparam int FRAC_BITS      = 16;
  localparam int LOG_TABLE_BITS = 10;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int DB_W     = 16;
  localparam int BYTE_W   = 8;
  localparam int EXP_W    = 8;
  localparam int MANT_W   = 24;

  // log2 / dB conversion
  localparam int LOGV_W = EXP_W + 1 + LOG_TABLE_BITS;
  localparam int MAG_W  = LOGV_W - 1;
  localparam int K_W    = 18;
  localparam logic [K_W-1:0] DB_PER_OCTAVE = K_W'(197283);
  localparam int P_W    = MAG_W + K_W;
  localparam int DB_SH  = LOG_TABLE_BITS + 16 - 8;
  localparam int R_W    = P_W - DB_SH;
  localparam logic [EXP_W-1:0] EXP_BIAS = EXP_W'(127);
  localparam logic [EXP_W-1:0] EXP_ALL1 = '1;

  localparam logic signed [DB_W-1:0] DB_MAX_V = 16'sh7FFF;
  localparam logic signed [DB_W-1:0] DB_MIN_V = 16'sh8000;

  // normalized values and color math
  localparam int NORM_W = FRAC_BITS + 1;
  localparam int HUE_W  = FRAC_BITS + 9;
  localparam int X_W    = FRAC_BITS + 6;
  localparam int C_W    = FRAC_BITS + 3;
  localparam int D_W    = FRAC_BITS + 2;
  localparam int PR_W   = D_W + X_W;
  localparam int QN_W   = PR_W - (FRAC_BITS + 2);
  localparam int DIV15_K = QN_W + 4;
  localparam int M_W    = DIV15_K - 3;
  localparam logic [M_W-1:0] DIV15_M = M_W'(((longint'(1) << DIV15_K) + 14) / 15);
  localparam int QM_W   = QN_W + M_W;

  localparam logic [NORM_W-1:0] ONE_V  = NORM_W'(longint'(1) << FRAC_BITS);
  localparam logic [NORM_W-1:0] HALF_V = NORM_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic [HUE_W-1:0]  DEG60  = HUE_W'(longint'(60) << FRAC_BITS);
  localparam logic [HUE_W-1:0]  DEG120 = HUE_W'(longint'(120) << FRAC_BITS);
  localparam logic [HUE_W-1:0]  DEG180 = HUE_W'(longint'(180) << FRAC_BITS);
  localparam logic [HUE_W-1:0]  DEG240 = HUE_W'(longint'(240) << FRAC_BITS);
  localparam logic [HUE_W-1:0]  DEG360 = HUE_W'(longint'(360) << FRAC_BITS);
  localparam logic [HUE_W-1:0]  HUE_SCALE = HUE_W'(360);

  // pipeline depth
  localparam int CHAN_LAT   = LOG_TABLE_BITS + FRAC_BITS + 5;
  localparam int POST_LAT   = 6;
  localparam int PIPE_DEPTH = CHAN_LAT + POST_LAT;

  // configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_MIN,
    CFG_HUE_MAX,
    CFG_SAT_MIN,
    CFG_SAT_MAX,
    CFG_LUM_MIN,
    CFG_LUM_MAX,
    CFG_FLOOR
  } cfg_idx_t;

  localparam logic signed [DB_W-1:0] WIN_MIN_RST = -16'sd7680;
  localparam logic signed [DB_W-1:0] WIN_MAX_RST = 16'sd0;
  localparam logic signed [DB_W-1:0] FLOOR_RST   = -16'sd25600;

  // segment of the hue ramp
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // dB window of one channel
  typedef struct packed {
    logic signed [DB_W-1:0] lo;
    logic signed [DB_W-1:0] hi;
  } win_t;

endpackage

[hdl/dbhsl_chan_db.sv]
// ---------------------------------------------------------------------------
// dbhsl_chan_db
// One channel: IEEE single sample to Q9.7 dB, window clamp, normalize to 0..1.
// ---------------------------------------------------------------------------
module dbhsl_chan_db (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [dbhsl_pkg::SAMPLE_W-1:0]       sample,
  input  logic signed [dbhsl_pkg::DB_W-1:0]    floor_db,
  input  dbhsl_pkg::win_t                      win,
  output logic [dbhsl_pkg::NORM_W-1:0]         norm
);
  import dbhsl_pkg::*;

  // log2 fraction by repeated squaring, one square per stage
  logic [EXP_W-1:0]          e_r  [LOG_TABLE_BITS+1];
  logic [MANT_W-1:0]         y_r  [LOG_TABLE_BITS+1];
  logic [LOG_TABLE_BITS-1:0] fr_r [LOG_TABLE_BITS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0]  <= sample[SAMPLE_W-2:MANT_W-1];
      y_r[0]  <= {1'b1, sample[MANT_W-2:0]};
      fr_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < LOG_TABLE_BITS; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    assign sq = y_r[k] * y_r[k];
    assign t  = sq[2*MANT_W-1:MANT_W-1];
    always_ff @(posedge clk) begin
      if (adv) begin
        e_r[k+1]  <= e_r[k];
        y_r[k+1]  <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        fr_r[k+1] <= {fr_r[k][LOG_TABLE_BITS-2:0], t[MANT_W]};
      end
    end
  end

  // scale log2 to dB
  logic signed [LOGV_W-1:0] v;
  logic [MAG_W-1:0]         mag;
  logic [P_W-1:0]           p_r;
  logic                     neg_r, zero_r, inf_r;

  always_comb begin
    v   = $signed({1'b0, e_r[LOG_TABLE_BITS], fr_r[LOG_TABLE_BITS]})
        - $signed({1'b0, EXP_BIAS, {LOG_TABLE_BITS{1'b0}}});
    mag = v[LOGV_W-1] ? MAG_W'(-v) : MAG_W'(v);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r    <= P_W'(mag) * P_W'(DB_PER_OCTAVE);
      neg_r  <= v[LOGV_W-1];
      zero_r <= (e_r[LOG_TABLE_BITS] == '0);
      inf_r  <= (e_r[LOG_TABLE_BITS] == EXP_ALL1);
    end
  end

  // round, saturate, floor
  logic [P_W-1:0]           rnd;
  logic [R_W-1:0]           rmag;
  logic signed [R_W:0]      sdb;
  logic signed [DB_W-1:0]   sat, db_nxt, db_r;

  always_comb begin
    rnd  = p_r + P_W'(longint'(1) << (DB_SH - 1));
    rmag = rnd[P_W-1:DB_SH];
    sdb  = neg_r ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    if (sdb > DB_MAX_V)      sat = DB_MAX_V;
    else if (sdb < DB_MIN_V) sat = DB_MIN_V;
    else                     sat = sdb[DB_W-1:0];
    if (zero_r)              db_nxt = floor_db;
    else if (inf_r)          db_nxt = DB_MAX_V;
    else if (sat <= floor_db) db_nxt = floor_db;
    else                     db_nxt = sat;
  end

  always_ff @(posedge clk) begin
    if (adv) db_r <= db_nxt;
  end

  // window clamp
  logic signed [DB_W-1:0] dc1, dc2;
  logic signed [DB_W:0]   den_s, num_s;
  logic [DB_W-1:0]        num_r, den_r;
  logic                   ok0_r;

  always_comb begin
    dc1   = (db_r > win.hi) ? win.hi : db_r;
    dc2   = (dc1 < win.lo) ? win.lo : dc1;
    den_s = $signed({win.hi[DB_W-1], win.hi}) - $signed({win.lo[DB_W-1], win.lo});
    num_s = $signed({dc2[DB_W-1], dc2}) - $signed({win.lo[DB_W-1], win.lo});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_s[DB_W-1:0];
      den_r <= den_s[DB_W-1:0];
      ok0_r <= (den_s > $signed((DB_W+1)'(0)));
    end
  end

  // restoring division, one quotient bit per stage
  logic [DB_W-1:0]   rem_r [FRAC_BITS+1];
  logic [DB_W-1:0]   dv_r  [FRAC_BITS+1];
  logic [NORM_W-1:0] q_r   [FRAC_BITS+1];
  logic              ok_r  [FRAC_BITS+1];

  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_div
    logic [DB_W:0]     t;
    logic [DB_W-1:0]   dsr;
    logic [NORM_W-1:0] qin;
    logic              okin, qb;
    if (j == 0) begin : g_first
      assign t    = {1'b0, num_r};
      assign dsr  = den_r;
      assign qin  = '0;
      assign okin = ok0_r;
    end else begin : g_next
      assign t    = {rem_r[j-1], 1'b0};
      assign dsr  = dv_r[j-1];
      assign qin  = q_r[j-1];
      assign okin = ok_r[j-1];
    end
    assign qb = (t >= {1'b0, dsr});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j] <= qb ? DB_W'(t - {1'b0, dsr}) : t[DB_W-1:0];
        dv_r[j]  <= dsr;
        q_r[j]   <= {qin[NORM_W-2:0], qb};
        ok_r[j]  <= okin;
      end
    end
  end

  // empty or inverted window gives zero
  assign norm = ok_r[FRAC_BITS] ? q_r[FRAC_BITS] : '0;

endmodule

[hdl/db_hsl_to_rgb_pixel_unit.sv]
// ---------------------------------------------------------------------------
// db_hsl_to_rgb_pixel_unit
// Three dB-scaled float samples per pixel mapped through HSL to an RGB byte triple.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in_     | input     | in_item_valid/in_stall  | hue/sat/lum samples, pixel_valid
//  out_    | output    | out_valid/out_stall     | red/green/blue bytes
//  cfg_    | input     | cfg_valid/cfg_ready     | cfg_index (3 bits), cfg_data (16 bits)
//
//  one item per cycle while the output is not stalled; the pipeline computes one
//  mantissa square per log stage and one quotient bit per division stage
//  rst_n clears the valid bits and loads the dB windows and floor defaults
//  the whole pipeline holds while a result sits stalled in the output register
//  cfg_ready is always high; writes land in the cycle they are offered
// ---------------------------------------------------------------------------
module db_hsl_to_rgb_pixel_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_item_valid,
  output logic                                 in_stall,
  input  logic [dbhsl_pkg::SAMPLE_W-1:0]       in_hue_sample,
  input  logic [dbhsl_pkg::SAMPLE_W-1:0]       in_sat_sample,
  input  logic [dbhsl_pkg::SAMPLE_W-1:0]       in_lum_sample,
  input  logic                                 in_pixel_valid,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dbhsl_pkg::BYTE_W-1:0]         out_red_byte,
  output logic [dbhsl_pkg::BYTE_W-1:0]         out_green_byte,
  output logic [dbhsl_pkg::BYTE_W-1:0]         out_blue_byte,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dbhsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbhsl_pkg::DB_W-1:0]           cfg_data
);
  import dbhsl_pkg::*;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  win_t                   hue_win_r, sat_win_r, lum_win_r;
  logic signed [DB_W-1:0] floor_db_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_win_r  <= '{lo: WIN_MIN_RST, hi: WIN_MAX_RST};
      sat_win_r  <= '{lo: WIN_MIN_RST, hi: WIN_MAX_RST};
      lum_win_r  <= '{lo: WIN_MIN_RST, hi: WIN_MAX_RST};
      floor_db_r <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HUE_MIN: hue_win_r.lo <= $signed(cfg_data);
        CFG_HUE_MAX: hue_win_r.hi <= $signed(cfg_data);
        CFG_SAT_MIN: sat_win_r.lo <= $signed(cfg_data);
        CFG_SAT_MAX: sat_win_r.hi <= $signed(cfg_data);
        CFG_LUM_MIN: lum_win_r.lo <= $signed(cfg_data);
        CFG_LUM_MAX: lum_win_r.hi <= $signed(cfg_data);
        CFG_FLOOR:   floor_db_r   <= $signed(cfg_data);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------------------
  // pipeline control: one global advance, valid bits shift with the data
  // ------------------------------------------------------------------
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  pv_r [PIPE_DEPTH-1];

  assign adv       = !vld_r[PIPE_DEPTH-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_item_valid};
    end
  end

  // pixel mask rides alongside the samples
  always_ff @(posedge clk) begin
    if (adv) begin
      pv_r[0] <= in_pixel_valid;
      for (int i = 1; i < PIPE_DEPTH - 1; i++) pv_r[i] <= pv_r[i-1];
    end
  end

  // ------------------------------------------------------------------
  // per-channel dB and normalize (CHAN_LAT stages each)
  // ------------------------------------------------------------------
  logic [NORM_W-1:0] hn, sn, ln;

  dbhsl_chan_db u_hue (
    .clk(clk), .adv(adv), .sample(in_hue_sample),
    .floor_db(floor_db_r), .win(hue_win_r), .norm(hn)
  );

  dbhsl_chan_db u_sat (
    .clk(clk), .adv(adv), .sample(in_sat_sample),
    .floor_db(floor_db_r), .win(sat_win_r), .norm(sn)
  );

  dbhsl_chan_db u_lum (
    .clk(clk), .adv(adv), .sample(in_lum_sample),
    .floor_db(floor_db_r), .win(lum_win_r), .norm(ln)
  );

  // ------------------------------------------------------------------
  // P0: hue in degrees, lightness products
  // ------------------------------------------------------------------
  logic [2*NORM_W:0]   pa_full;
  logic [2*NORM_W-1:0] pb_full;
  logic [HUE_W-1:0]    hue0_r;
  logic [NORM_W-1:0]   l0_r, s0_r, pb0_r;
  logic [NORM_W:0]     pa0_r;
  logic                gray0_r;

  assign pa_full = (2*NORM_W+1)'(ln) * (2*NORM_W+1)'({1'b0, ONE_V} + {1'b0, sn});
  assign pb_full = (2*NORM_W)'(ln) * (2*NORM_W)'(sn);

  always_ff @(posedge clk) begin
    if (adv) begin
      hue0_r  <= HUE_W'(hn) * HUE_SCALE;
      l0_r    <= ln;
      s0_r    <= sn;
      pa0_r   <= pa_full[FRAC_BITS+NORM_W:FRAC_BITS];
      pb0_r   <= pb_full[FRAC_BITS+NORM_W-1:FRAC_BITS];
      gray0_r <= (sn == '0);
    end
  end

  // ------------------------------------------------------------------
  // P1: m2 and the three hue angles, wrapped into 0..360
  // ------------------------------------------------------------------
  logic signed [C_W-1:0] m2_1_nxt, m2_1_r;
  logic [HUE_W-1:0]      h1_nxt [3];
  logic [HUE_W-1:0]      h1_r   [3];
  logic [NORM_W-1:0]     l1_r;
  logic                  gray1_r;

  always_comb begin
    if (l0_r <= HALF_V) m2_1_nxt = $signed(C_W'(pa0_r));
    else m2_1_nxt = $signed(C_W'(l0_r) + C_W'(s0_r) - C_W'(pb0_r));
    // red leads by 120 degrees, blue trails by 120
    h1_nxt[0] = (hue0_r > DEG240) ? hue0_r - DEG240 : hue0_r + DEG120;
    h1_nxt[1] = hue0_r;
    h1_nxt[2] = (hue0_r < DEG120) ? hue0_r + DEG240 : hue0_r - DEG120;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_1_r  <= m2_1_nxt;
      h1_r    <= h1_nxt;
      l1_r    <= l0_r;
      gray1_r <= gray0_r;
    end
  end

  // ------------------------------------------------------------------
  // P2: m1, ramp height, ramp segment and offset per color
  // ------------------------------------------------------------------
  logic signed [C_W-1:0] m1_nxt, dd;
  logic [D_W-1:0]        d_nxt;
  seg_t                  seg_nxt [3];
  logic [X_W-1:0]        x_nxt   [3];
  logic signed [C_W-1:0] m1_2_r, m2_2_r;
  logic [D_W-1:0]        d2_r;
  seg_t                  seg2_r [3];
  logic [X_W-1:0]        x2_r   [3];
  logic [NORM_W-1:0]     l2_r;
  logic                  gray2_r;

  always_comb begin
    m1_nxt = $signed(C_W'({l1_r, 1'b0})) - m2_1_r;
    dd     = m2_1_r - m1_nxt;
    d_nxt  = dd[C_W-1] ? '0 : D_W'(dd);
    for (int c = 0; c < 3; c++) begin
      if (h1_r[c] < DEG60) begin
        seg_nxt[c] = SEG_RISE;
        x_nxt[c]   = X_W'(h1_r[c]);
      end else if (h1_r[c] < DEG180) begin
        seg_nxt[c] = SEG_HIGH;
        x_nxt[c]   = '0;
      end else if (h1_r[c] < DEG240) begin
        seg_nxt[c] = SEG_FALL;
        x_nxt[c]   = X_W'(DEG240 - h1_r[c]);
      end else begin
        seg_nxt[c] = SEG_LOW;
        x_nxt[c]   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_2_r  <= m1_nxt;
      m2_2_r  <= m2_1_r;
      d2_r    <= d_nxt;
      seg2_r  <= seg_nxt;
      x2_r    <= x_nxt;
      l2_r    <= l1_r;
      gray2_r <= gray1_r;
    end
  end

  // ------------------------------------------------------------------
  // P3: ramp product, pre-shifted by 2^FRAC_BITS * 4 (60 = 4 * 15)
  // ------------------------------------------------------------------
  logic [PR_W-1:0]       prod [3];
  logic [QN_W-1:0]       n3_r [3];
  seg_t                  seg3_r [3];
  logic signed [C_W-1:0] m1_3_r, m2_3_r;
  logic [NORM_W-1:0]     l3_r;
  logic                  gray3_r;

  always_comb begin
    for (int c = 0; c < 3; c++) prod[c] = PR_W'(d2_r) * PR_W'(x2_r[c]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) n3_r[c] <= prod[c][PR_W-1:FRAC_BITS+2];
      seg3_r  <= seg2_r;
      m1_3_r  <= m1_2_r;
      m2_3_r  <= m2_2_r;
      l3_r    <= l2_r;
      gray3_r <= gray2_r;
    end
  end

  // ------------------------------------------------------------------
  // P4: exact divide by 15 through a reciprocal multiply
  // ------------------------------------------------------------------
  logic [QM_W-1:0]       qm [3];
  logic [D_W-1:0]        quot4_r [3];
  seg_t                  seg4_r [3];
  logic signed [C_W-1:0] m1_4_r, m2_4_r;
  logic [NORM_W-1:0]     l4_r;
  logic                  gray4_r;

  always_comb begin
    for (int c = 0; c < 3; c++) qm[c] = QM_W'(n3_r[c]) * QM_W'(DIV15_M);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) quot4_r[c] <= qm[c][DIV15_K+D_W-1:DIV15_K];
      seg4_r  <= seg3_r;
      m1_4_r  <= m1_3_r;
      m2_4_r  <= m2_3_r;
      l4_r    <= l3_r;
      gray4_r <= gray3_r;
    end
  end

  // ------------------------------------------------------------------
  // P5: pick the ramp value, clamp to 0..1, scale to a byte
  // ------------------------------------------------------------------
  logic signed [C_W:0]      cv [3];
  logic [NORM_W-1:0]        cc [3];
  logic [NORM_W+BYTE_W-1:0] sc [3];
  logic [BYTE_W-1:0]        byte_nxt [3];
  logic [BYTE_W-1:0]        red_r, green_r, blue_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (gray4_r) begin
        cv[c] = $signed((C_W+1)'(l4_r));
      end else begin
        case (seg4_r[c])
          SEG_RISE, SEG_FALL:
            cv[c] = (C_W+1)'(m1_4_r) + $signed((C_W+1)'(quot4_r[c]));
          SEG_HIGH: cv[c] = (C_W+1)'(m2_4_r);
          default:  cv[c] = (C_W+1)'(m1_4_r);
        endcase
      end
      if (cv[c][C_W])                    cc[c] = '0;
      else if (cv[c][C_W-1:0] > C_W'(ONE_V)) cc[c] = ONE_V;
      else                               cc[c] = NORM_W'(cv[c]);
      // 255 * c as 256 * c - c
      sc[c]       = {cc[c], {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, cc[c]};
      byte_nxt[c] = sc[c][FRAC_BITS+BYTE_W-1:FRAC_BITS];
    end
  end

  // masked pixels get the fixed marker color
  always_ff @(posedge clk) begin
    if (adv) begin
      if (pv_r[PIPE_DEPTH-2]) begin
        red_r   <= byte_nxt[0];
        green_r <= byte_nxt[1];
        blue_r  <= byte_nxt[2];
      end else begin
        red_r   <= '0;
        green_r <= BYTE_W'(1);
        blue_r  <= '0;
      end
    end
  end

  assign out_red_byte   = red_r;
  assign out_green_byte = green_r;
  assign out_blue_byte  = blue_r;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_freeze_holds_valids: assert property (
    @(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r)
  ) else $error("valid bits moved while the pipeline was held");

  a_gray_pixel: assert property (
    @(posedge clk) disable iff (!rst_n)
    adv && vld_r[PIPE_DEPTH-2] && pv_r[PIPE_DEPTH-2] && gray4_r |=>
      (out_red_byte == out_green_byte) && (out_green_byte == out_blue_byte)
  ) else $error("zero saturation pixel is not gray");

  a_masked_pixel: assert property (
    @(posedge clk) disable iff (!rst_n)
    adv && vld_r[PIPE_DEPTH-2] && !pv_r[PIPE_DEPTH-2] |=>
      (out_red_byte == '0) && (out_green_byte == BYTE_W'(1)) && (out_blue_byte == '0)
  ) else $error("masked pixel color wrong");
`endif

endmodule
